>>> sv/boot_password_attempt_gate_defines.svh
// ---------------------------------------------------------------------------
// boot_password_attempt_gate_defines
// assertion macros shared by the boot gate modules
// ---------------------------------------------------------------------------
`ifndef BOOT_PASSWORD_ATTEMPT_GATE_DEFINES_SVH
`define BOOT_PASSWORD_ATTEMPT_GATE_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("boot gate assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("boot gate assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/bpag_pkg.sv
// ---------------------------------------------------------------------------
// bpag_pkg
// types, codes and helpers of the boot password attempt gate
// ---------------------------------------------------------------------------
package bpag_pkg;

    // operation codes
    localparam logic OP_BOOT    = 1'b0;
    localparam logic OP_ATTEMPT = 1'b1;

    // verdict codes
    localparam logic [2:0] V_PROMPT  = 3'd0;
    localparam logic [2:0] V_PASS    = 3'd1;
    localparam logic [2:0] V_WIPE    = 3'd2;
    localparam logic [2:0] V_HALTED  = 3'd3;
    localparam logic [2:0] V_WRONG   = 3'd4;
    localparam logic [2:0] V_LOCKED  = 3'd5;
    localparam logic [2:0] V_IGNORED = 3'd6;

    // wipe reason codes
    localparam logic [1:0] REASON_NONE     = 2'd0;
    localparam logic [1:0] REASON_ARM_LINE = 2'd1;
    localparam logic [1:0] REASON_COUNT    = 2'd2;
    localparam logic [1:0] REASON_HOST     = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_PROVISIONED  = 3'd0;
    localparam logic [2:0] CFG_ARMED        = 3'd1;
    localparam logic [2:0] CFG_DEADMAN_MODE = 3'd2;
    localparam logic [2:0] CFG_MAX_ATTEMPTS = 3'd3;
    localparam logic [2:0] CFG_MAX_RESUMES  = 3'd4;

    localparam logic [7:0]  MAX_ATTEMPTS_RST = 8'd10;
    localparam logic [7:0]  MAX_RESUMES_RST  = 8'd3;
    localparam logic [7:0]  COUNT_MAX        = 8'hFF;
    localparam logic [11:0] BACKOFF_STEP     = 12'd500;
    localparam logic [11:0] BACKOFF_CAP      = 12'd3000;

    typedef struct packed {
        logic       provisioned;
        logic       armed;
        logic       deadman_mode;
        logic [7:0] max_attempts;
        logic [7:0] max_resumes;
    } t_cfg;

    typedef struct packed {
        logic operation;
        logic low_supply;
        logic tombstone_set;
        logic line_armed;
        logic password_ok;
        logic wipe_request;
        logic persist_ok;
    } t_item;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [1:0]  wipe_reason;
        logic [7:0]  attempts_left;
        logic [11:0] backoff_ms;
        logic        clear_tombstone;
    } t_res;

    // 500 ms per wrong attempt, capped at 3000 ms (cap reached from six on)
    function automatic logic [11:0] backoff_for(input logic [7:0] count);
        logic [11:0] ms;
        if (count >= 8'd6) begin
            ms = BACKOFF_CAP;
        end else begin
            ms = 12'(BACKOFF_STEP * {9'd0, count[2:0]});
        end
        return ms;
    endfunction

endpackage

>>> sv/bpag_cfg.sv
// ---------------------------------------------------------------------------
// bpag_cfg
// configuration registers, written by index, no read-back
// ---------------------------------------------------------------------------
module bpag_cfg
    import bpag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.provisioned  <= 1'b0;
            r_cfg.armed        <= 1'b0;
            r_cfg.deadman_mode <= 1'b0;
            r_cfg.max_attempts <= MAX_ATTEMPTS_RST;
            r_cfg.max_resumes  <= MAX_RESUMES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PROVISIONED:  r_cfg.provisioned  <= i_cfg_data[0];
                CFG_ARMED:        r_cfg.armed        <= i_cfg_data[0];
                CFG_DEADMAN_MODE: r_cfg.deadman_mode <= i_cfg_data[0];
                CFG_MAX_ATTEMPTS: r_cfg.max_attempts <= i_cfg_data;
                CFG_MAX_RESUMES:  r_cfg.max_resumes  <= i_cfg_data;
                default: begin
                    // unknown index, write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/bpag_decide.sv
// ---------------------------------------------------------------------------
// bpag_decide
// boot and attempt decision logic with the gate's persistent state
// ---------------------------------------------------------------------------
`include "boot_password_attempt_gate_defines.svh"

module bpag_decide
    import bpag_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_fire,
    input  t_item i_item,
    output t_res  o_res
);

    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_PROMPT = 2'd1;
    localparam logic [1:0] PHASE_HALTED = 2'd2;

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_wrong_count, n_wrong_count;
    logic [7:0] r_resume_count, n_resume_count;
    logic       r_supply_low, n_supply_low;

    logic       w_open;
    logic [7:0] w_wrong_inc;
    logic [7:0] w_wrong_new;
    t_res       w_res;

    assign w_open      = !i_cfg.provisioned || !i_cfg.armed;
    assign w_wrong_inc = (r_wrong_count != COUNT_MAX) ? r_wrong_count + 8'd1 : r_wrong_count;
    // a failed persist fails closed to the limit
    assign w_wrong_new = i_item.persist_ok ? w_wrong_inc : i_cfg.max_attempts;

    always_comb begin
        n_phase        = r_phase;
        n_wrong_count  = r_wrong_count;
        n_resume_count = r_resume_count;
        n_supply_low   = r_supply_low;
        w_res          = '0;
        w_res.verdict  = V_PROMPT;

        if (i_item.operation == OP_BOOT) begin
            n_supply_low = i_item.low_supply;
            n_phase      = PHASE_IDLE;
            if (i_item.tombstone_set && w_open) begin
                // cleanup of a wipe that an unprovisioned or disarmed board left behind
                n_resume_count        = 8'd0;
                w_res.verdict         = V_PASS;
                w_res.clear_tombstone = 1'b1;
            end else if (i_item.tombstone_set && !i_item.low_supply) begin
                if (r_resume_count >= i_cfg.max_resumes) begin
                    n_phase       = PHASE_HALTED;
                    w_res.verdict = V_HALTED;
                end else begin
                    if (r_resume_count != COUNT_MAX) begin
                        n_resume_count = r_resume_count + 8'd1;
                    end
                    w_res.verdict     = V_WIPE;
                    w_res.wipe_reason = REASON_COUNT;
                end
            end else if (w_open) begin
                w_res.verdict = V_PASS;
            end else if (i_cfg.deadman_mode && !i_item.low_supply && !i_item.line_armed) begin
                w_res.verdict     = V_WIPE;
                w_res.wipe_reason = REASON_ARM_LINE;
            end else begin
                // deferred tombstone lands here too
                n_phase       = PHASE_PROMPT;
                w_res.verdict = V_PROMPT;
            end
        end else if (r_phase != PHASE_PROMPT) begin
            w_res.verdict = V_IGNORED;
        end else if (i_item.password_ok) begin
            n_phase = PHASE_IDLE;
            if (i_item.wipe_request && !r_supply_low) begin
                w_res.verdict     = V_WIPE;
                w_res.wipe_reason = REASON_HOST;
            end else begin
                n_wrong_count = 8'd0;
                w_res.verdict = V_PASS;
            end
        end else begin
            n_wrong_count = w_wrong_new;
            if (w_wrong_new != 8'd0 && w_wrong_new >= i_cfg.max_attempts) begin
                if (r_supply_low) begin
                    w_res.verdict    = V_LOCKED;
                    w_res.backoff_ms = backoff_for(w_wrong_new);
                end else begin
                    n_phase           = PHASE_IDLE;
                    w_res.verdict     = V_WIPE;
                    w_res.wipe_reason = REASON_COUNT;
                end
            end else begin
                w_res.verdict       = V_WRONG;
                w_res.attempts_left = (w_wrong_new >= i_cfg.max_attempts) ? 8'd0
                                    : i_cfg.max_attempts - w_wrong_new;
                w_res.backoff_ms    = backoff_for(w_wrong_new);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PHASE_IDLE;
            r_wrong_count  <= 8'd0;
            r_resume_count <= 8'd0;
            r_supply_low   <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_wrong_count  <= n_wrong_count;
            r_resume_count <= n_resume_count;
            r_supply_low   <= n_supply_low;
        end
    end

    assign o_res = w_res;

    `ASSERT_NEXT(a_locked_keeps_prompt, i_clk, i_rst_n, i_fire && w_res.verdict == V_LOCKED, r_phase == PHASE_PROMPT)
    `ASSERT_NEXT(a_halt_sets_phase, i_clk, i_rst_n, i_fire && w_res.verdict == V_HALTED, r_phase == PHASE_HALTED)
    `ASSERT_NEXT(a_pass_clears_count, i_clk, i_rst_n, i_fire && i_item.operation == OP_ATTEMPT && w_res.verdict == V_PASS, r_wrong_count == 8'd0)

endmodule

>>> sv/boot_password_attempt_gate.sv
// ---------------------------------------------------------------------------
// boot_password_attempt_gate
// boot-time lockout controller: tombstone, dead-man and wrong-attempt gate
// ---------------------------------------------------------------------------
// usage:
//   s_axis carries one event word: tuser is the operation (0 boot,
//   1 password attempt), tdata the event flags. m_axis returns exactly one
//   result word per event, in order.
//   configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no event is in flight; index 0..4 selects provisioned, armed,
//   deadman_mode, max_attempts, max_resumes; other indexes are dropped.
//   a word accepted on s_axis is registered, decided from the input stage
//   and written to the result register when that one is free or draining.
//   throughput: one word per cycle unless m_axis stalls; the decision for
//   one event is a single register-to-register pass that also updates the
//   gate state.
//   reset (synchronous, active low) empties both stages, sets the phase to
//   idle, clears the wrong and resume counters and loads register defaults.
//   when m_axis_tready is low the result register holds; the input stage can
//   still take one more word, then s_axis_tready drops until the result
//   register drains.
// ---------------------------------------------------------------------------
`include "boot_password_attempt_gate_defines.svh"

module boot_password_attempt_gate
    import bpag_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data,
    // event stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // low_supply, tombstone_set, line_armed, password_ok, wipe_request,
    // persist_ok, 2 bits zero
    input  logic [7:0]  s_axis_tdata,
    // operation
    input  logic        s_axis_tuser,
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // verdict[2:0], wipe_reason[4:3], attempts_left[12:5], backoff_ms[24:13],
    // clear_tombstone[25], 6 bits zero
    output logic [31:0] m_axis_tdata
);

    t_cfg  w_cfg;
    t_res  w_res;
    logic  w_adv;
    logic  w_fire;

    logic  r_in_valid;
    t_item r_in_item;
    logic  r_out_valid;
    t_res  r_out_res;

    bpag_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    bpag_decide u_decide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_res   (w_res)
    );

    // result register free or being drained this cycle
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.operation     <= s_axis_tuser;
            r_in_item.low_supply    <= s_axis_tdata[0];
            r_in_item.tombstone_set <= s_axis_tdata[1];
            r_in_item.line_armed    <= s_axis_tdata[2];
            r_in_item.password_ok   <= s_axis_tdata[3];
            r_in_item.wipe_request  <= s_axis_tdata[4];
            r_in_item.persist_ok    <= s_axis_tdata[5];
        end
        if (w_fire) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_res.clear_tombstone, r_out_res.backoff_ms,
                            r_out_res.attempts_left, r_out_res.wipe_reason,
                            r_out_res.verdict};

    `ASSERT_IMPLIES(a_reason_only_on_wipe, i_clk, i_rst_n, r_out_valid && r_out_res.wipe_reason != REASON_NONE, r_out_res.verdict == V_WIPE)
    `ASSERT_IMPLIES(a_clear_only_on_pass, i_clk, i_rst_n, r_out_valid && r_out_res.clear_tombstone, r_out_res.verdict == V_PASS)
    `ASSERT_NEXT(a_input_stage_holds, i_clk, i_rst_n, r_in_valid && !w_adv, r_in_valid)

endmodule
